[sv/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types for the sorted point table: operation and status codes and
// the request and response words.
// ----------------------------------------------------------------------------
package spt_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EXISTS = 2'd1,
      ST_FULL   = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] frame;
      logic [5:0]         position;
   } req_type;

   typedef struct packed {
      logic [6:0]         slot;
      logic               already_present;
      status_type         status;
      logic [6:0]         entries;
      logic signed [31:0] read_time;
   } rsp_type;

endpackage

[sv/spt_store.sv]
// ----------------------------------------------------------------------------
// spt_store
// Single write port, single read port time store with registered read data.
// ----------------------------------------------------------------------------
module spt_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sorted_point_table.sv]
// ----------------------------------------------------------------------------
// sorted_point_table
// Ascending table of signed frame times with insert, delete and read.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req with a word and raise start; the word is taken on a rising edge
//   with start high and busy low. busy stays high while the sequencer works.
//   Exactly one response word per request appears on rsp for one cycle with
//   rsp_strobe high; the receiver has no way to hold it off.
// Sequence (N = entries):
//   read out of range, delete out of range, delete with one or no entries,
//   delete of the last entry and unknown ops finish without leaving idle;
//   the next request may follow at once. read: one store read, then answer.
//   insert: binary search (about log2(N)+1 steps, one store read each), a
//   step to close the search, a compare step, then one move per entry moved
//   up and a step to place the new frame.
//   delete: one move per entry moved down; the last move answers.
//   The single read port of the store paces the sequencer: every step of the
//   search and every move waits on one registered read.
// Reset: the entry count clears to zero; stored times are not cleared and
//   are never read before written.
// ----------------------------------------------------------------------------
module sorted_point_table #(
   parameter int CAPACITY = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  spt_pkg::req_type req,
   output logic            rsp_strobe,
   output spt_pkg::rsp_type rsp
);
   import spt_pkg::*;

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_SEARCH   = 8'b0000_0010,
      S_SWAIT    = 8'b0000_0100,
      S_CHECK    = 8'b0000_1000,
      S_SHIFT_UP = 8'b0001_0000,
      S_PLACE    = 8'b0010_0000,
      S_SHIFT_DN = 8'b0100_0000,
      S_RDATA    = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [AW-1:0] mid_ff, mid_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [CW-1:0] count_ff, count_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_strobe_ff, rsp_strobe_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;

   logic [CW-1:0]   mid_w;
   logic [CMPW-1:0] pos_x;
   logic [CMPW-1:0] cnt_x;
   logic            is_below;

   spt_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid_w    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign pos_x    = CMPW'(req.position);
   assign cnt_x    = CMPW'(count_ff);
   assign is_below = $signed(rd_data) < req_ff.frame;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = AW'(cur_ff);
      wr_data       = rd_data;
      rd_addr       = AW'(lo_ff);

      // response defaults; fields are overridden per case below
      rsp_in.slot            = '0;
      rsp_in.already_present = 1'b0;
      rsp_in.status          = ST_OK;
      rsp_in.read_time       = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req;
               case (req.operation)
                  OP_INSERT: begin
                     lo_in    = '0;
                     hi_in    = count_ff;
                     state_in = S_SEARCH;
                  end
                  OP_DELETE: begin
                     if (cnt_x <= CMPW'(1)) begin
                        count_in      = '0;
                        rsp_strobe_in = 1'b1;
                     end else if (pos_x >= cnt_x) begin
                        rsp_in.status = ST_RANGE;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        cur_in = CW'(pos_x);
                        if (pos_x + CMPW'(1) < cnt_x) begin
                           rd_addr  = AW'(pos_x + CMPW'(1));
                           state_in = S_SHIFT_DN;
                        end else begin
                           count_in      = count_ff - CW'(1);
                           rsp_strobe_in = 1'b1;
                        end
                     end
                  end
                  OP_READ: begin
                     if (pos_x >= cnt_x) begin
                        rsp_in.status = ST_RANGE;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        rd_addr  = AW'(pos_x);
                        state_in = S_RDATA;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = AW'(mid_w);
               mid_in   = AW'(mid_w);
               state_in = S_SWAIT;
            end else begin
               rd_addr  = AW'(lo_ff);
               state_in = S_CHECK;
            end
         end
         S_SWAIT: begin
            if (is_below) begin
               lo_in = CW'(mid_ff) + CW'(1);
            end else begin
               hi_in = CW'(mid_ff);
            end
            state_in = S_SEARCH;
         end
         S_CHECK: begin
            rsp_in.slot = 7'(32'(lo_ff));
            if (lo_ff < count_ff && rd_data == req_ff.frame) begin
               rsp_in.already_present = 1'b1;
               rsp_in.status          = ST_EXISTS;
               rsp_strobe_in          = 1'b1;
               state_in               = S_IDLE;
            end else if (count_ff >= CW'(CAPACITY)) begin
               rsp_in.status = ST_FULL;
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (count_ff > lo_ff) begin
               rd_addr  = AW'(count_ff - CW'(1));
               cur_in   = count_ff;
               state_in = S_SHIFT_UP;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_SHIFT_UP: begin
            // write the word read last cycle one slot up, fetch the next
            wr_en = 1'b1;
            if (cur_ff - CW'(1) > lo_ff) begin
               rd_addr = AW'(cur_ff - CW'(2));
               cur_in  = cur_ff - CW'(1);
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            wr_en         = 1'b1;
            wr_addr       = AW'(lo_ff);
            wr_data       = req_ff.frame;
            count_in      = count_ff + CW'(1);
            rsp_in.slot   = 7'(32'(lo_ff));
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_SHIFT_DN: begin
            wr_en = 1'b1;
            if (cur_ff + CW'(2) < count_ff) begin
               rd_addr = AW'(cur_ff + CW'(2));
               cur_in  = cur_ff + CW'(1);
            end else begin
               count_in      = count_ff - CW'(1);
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RDATA: begin
            rsp_in.read_time = rd_data;
            rsp_strobe_in    = 1'b1;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.entries = 7'(32'(count_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

[sv/spt_checker.sv]
// ----------------------------------------------------------------------------
// spt_checker
// Port-level checks for the sorted point table, bound to the top level.
// ----------------------------------------------------------------------------
module spt_checker #(
   parameter int CAPACITY = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input spt_pkg::req_type req,
   input logic             rsp_strobe,
   input spt_pkg::rsp_type rsp
);
   import spt_pkg::*;

   localparam logic [6:0] CAP7 = 7'(32'(CAPACITY));

   // an accepted word either finishes at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted word neither answered nor in progress");

   // a response is only shown once the sequencer is back to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response word while busy");

   a_present_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp.already_present == (rsp.status == ST_EXISTS)))
      else $error("already_present disagrees with status");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.status == ST_FULL) |-> (rsp.entries == CAP7))
      else $error("full status with table not full");

endmodule

bind sorted_point_table spt_checker #(.CAPACITY(CAPACITY)) u_spt_checker (.*);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_point_table: a directed table of requests,
// then random fill/drain/mix phases, each response checked against a typed-in
// response or a local model of the sorted frame table.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spt_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_WORDS = 1350;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 120;

   typedef enum {PH_GROW, PH_SHRINK, PH_MIX} phase_type;

   typedef struct {
      req_type word;
      bit      pinned;
      rsp_type want;
   } row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_strobe;
   rsp_type rsp;

   // typed-in response riding along with the current request word
   bit      pin_valid;
   rsp_type pin_rsp;

   logic signed [31:0] model_times [TABLE_DEPTH];
   int                 model_count;
   rsp_type            pending_rsp [$];
   row_type            directed_rows [$];

   int accepted_words;
   int quiet_cycles;
   int fail_count;
   int n_insert, n_full, n_dup, n_delete, n_read, n_range, n_none, peak_count;

   sorted_point_table #(.CAPACITY(TABLE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_type outcome(int slot, bit present, status_type st, int entries,
                                       logic signed [31:0] rtime);
      rsp_type r;
      r.slot            = slot[6:0];
      r.already_present = present;
      r.status          = st;
      r.entries         = entries[6:0];
      r.read_time       = rtime;
      return r;
   endfunction

   function automatic row_type row(op_type op, logic signed [31:0] frame, int pos,
                                   bit pinned, rsp_type want);
      row_type d;
      d.word.operation = op;
      d.word.frame     = frame;
      d.word.position  = pos[5:0];
      d.pinned         = pinned;
      d.want           = want;
      return d;
   endfunction

   // Applies one request to the local table and returns the response it yields.
   function automatic rsp_type table_outcome(req_type word);
      rsp_type r;
      int lo, hi, mid, i, pos;
      r   = outcome(0, 1'b0, ST_OK, 0, 32'sd0);
      pos = int'(word.position);
      case (op_type'(word.operation))
         OP_INSERT: begin
            n_insert++;
            lo = 0;
            hi = model_count;
            while (lo < hi) begin
               mid = lo + ((hi - lo) >> 1);
               if (model_times[mid] < word.frame) lo = mid + 1;
               else hi = mid;
            end
            r.slot = lo[6:0];
            if (lo < model_count && model_times[lo] == word.frame) begin
               r.already_present = 1'b1;
               r.status          = ST_EXISTS;
               n_dup++;
            end else if (model_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
               n_full++;
            end else begin
               for (i = model_count; i > lo; i--) model_times[i] = model_times[i - 1];
               model_times[lo] = word.frame;
               model_count++;
            end
         end
         OP_DELETE: begin
            n_delete++;
            if (model_count <= 1) begin
               model_count = 0;
            end else if (pos >= model_count) begin
               r.status = ST_RANGE;
               n_range++;
            end else begin
               for (i = pos; i + 1 < model_count; i++) model_times[i] = model_times[i + 1];
               model_count--;
            end
         end
         OP_READ: begin
            n_read++;
            if (pos >= model_count) begin
               r.status = ST_RANGE;
               n_range++;
            end else begin
               r.read_time = model_times[pos];
            end
         end
         default: n_none++;
      endcase
      if (model_count > peak_count) peak_count = model_count;
      r.entries = model_count[6:0];
      return r;
   endfunction

   // Request words are taken at the edge with start high and busy low; responses
   // are strobed for one cycle and cannot be held off.
   always @(posedge clock) begin : monitor
      rsp_type want;
      bit      active;
      if (!reset) begin
         active = 1'b0;
         if (start && !busy) begin
            want = table_outcome(req);
            pending_rsp.push_back(pin_valid ? pin_rsp : want);
            accepted_words++;
            active = 1'b1;
         end
         if (rsp_strobe) begin
            active = 1'b1;
            if (pending_rsp.size() == 0) begin
               if (fail_count < 10)
                  $display("[%0t] response word with no request outstanding: slot %0d status %0d",
                           $realtime, rsp.slot, rsp.status);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp.slot !== want.slot || rsp.already_present !== want.already_present ||
                   rsp.status !== want.status || rsp.entries !== want.entries ||
                   rsp.read_time !== want.read_time) begin
                  if (fail_count < 10) begin
                     $display("[%0t] mismatch exp slot %0d present %0d status %0d entries %0d time %0d",
                              $realtime, want.slot, want.already_present, want.status,
                              want.entries, want.read_time);
                     $display("[%0t]          got slot %0d present %0d status %0d entries %0d time %0d",
                              $realtime, rsp.slot, rsp.already_present, rsp.status,
                              rsp.entries, rsp.read_time);
                  end
                  fail_count++;
               end
            end
         end
         quiet_cycles = active ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("sorted_point_table verification failed");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(req_type word, bit pinned, rsp_type want, int gap);
      int seen;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      seen      = accepted_words;
      start     <= 1'b1;
      req       <= word;
      pin_valid <= pinned;
      pin_rsp   <= want;
      do @(negedge clock); while (accepted_words == seen);
   endtask

   initial begin : stimulus
      rsp_type   none_rsp;
      req_type   word;
      phase_type kind;
      bit        calm;
      int        sent, len, k, roll, gap, v, c;
      reset          = 1'b1;
      start          = 1'b0;
      req            = '0;
      pin_valid      = 1'b0;
      pin_rsp        = '0;
      model_count    = 0;
      accepted_words = 0;
      quiet_cycles   = 0;
      fail_count     = 0;
      none_rsp       = '0;
      for (k = 0; k < TABLE_DEPTH; k++) model_times[k] = '0;

      directed_rows.push_back(row(OP_READ, 32'sd0, 0, 1, outcome(0, 0, ST_RANGE, 0, 0)));
      directed_rows.push_back(row(OP_DELETE, 32'sd0, 5, 1, outcome(0, 0, ST_OK, 0, 0)));
      directed_rows.push_back(row(OP_NONE, 32'h12345678, 21, 1, outcome(0, 0, ST_OK, 0, 0)));
      directed_rows.push_back(row(OP_INSERT, 32'sd0, 0, 1, outcome(0, 0, ST_OK, 1, 0)));
      directed_rows.push_back(row(OP_INSERT, 32'sd0, 7, 1, outcome(0, 1, ST_EXISTS, 1, 0)));
      // one entry left: delete clears regardless of index
      directed_rows.push_back(row(OP_DELETE, 32'sd0, 63, 1, outcome(0, 0, ST_OK, 0, 0)));
      directed_rows.push_back(row(OP_INSERT, 32'h7fffffff, 0, 1, outcome(0, 0, ST_OK, 1, 0)));
      directed_rows.push_back(row(OP_INSERT, 32'h80000000, 0, 1, outcome(0, 0, ST_OK, 2, 0)));
      directed_rows.push_back(row(OP_INSERT, -32'sd1, 0, 1, outcome(1, 0, ST_OK, 3, 0)));
      directed_rows.push_back(row(OP_INSERT, 32'sd1, 0, 0, none_rsp));
      directed_rows.push_back(row(OP_READ, 32'sd0, 0, 1,
                                  outcome(0, 0, ST_OK, 4, 32'h80000000)));
      directed_rows.push_back(row(OP_READ, 32'hffffffff, 3, 1,
                                  outcome(0, 0, ST_OK, 4, 32'h7fffffff)));
      directed_rows.push_back(row(OP_READ, 32'sd0, 4, 1, outcome(0, 0, ST_RANGE, 4, 0)));
      directed_rows.push_back(row(OP_DELETE, 32'sd0, 63, 1, outcome(0, 0, ST_RANGE, 4, 0)));
      directed_rows.push_back(row(OP_INSERT, -32'sd1, 0, 1, outcome(1, 1, ST_EXISTS, 4, 0)));
      directed_rows.push_back(row(OP_INSERT, 32'h7fffffff, 0, 1,
                                  outcome(3, 1, ST_EXISTS, 4, 0)));
      directed_rows.push_back(row(OP_DELETE, 32'sd0, 0, 0, none_rsp));
      directed_rows.push_back(row(OP_READ, 32'sd0, 0, 0, none_rsp));
      directed_rows.push_back(row(OP_DELETE, 32'sd0, 2, 0, none_rsp));
      directed_rows.push_back(row(OP_INSERT, 32'h55555555, 42, 0, none_rsp));
      directed_rows.push_back(row(OP_INSERT, 32'haaaaaaaa, 21, 0, none_rsp));
      directed_rows.push_back(row(OP_NONE, 32'hffffffff, 63, 0, none_rsp));
      directed_rows.push_back(row(OP_READ, 32'sd0, 1, 0, none_rsp));

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].pinned, directed_rows[i].want,
                   (i % 3 == 2) ? int'($urandom_range(1, 4)) : 0);

      // Random phases: fill toward full, drain toward empty, or a flat mix.
      // Ignored ops do not count toward the total.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         kind = phase_type'($urandom_range(0, 2));
         calm = ($urandom_range(0, 3) == 0);
         len  = (kind == PH_GROW) ? 120 : (kind == PH_SHRINK) ? 70 : 50;
         for (k = 0; k < len && sent < RANDOM_WORDS; k++) begin
            roll = $urandom_range(0, 99);
            case (kind)
               PH_GROW:   word.operation = (roll < 80) ? OP_INSERT :
                                           (roll < 90) ? OP_READ : OP_DELETE;
               PH_SHRINK: word.operation = (roll < 70) ? OP_DELETE :
                                           (roll < 90) ? OP_READ : OP_INSERT;
               default:   word.operation = (roll < 35) ? OP_INSERT :
                                           (roll < 65) ? OP_DELETE :
                                           (roll < 94) ? OP_READ : OP_NONE;
            endcase

            // narrow band for duplicates, full range, extremes, or a stored time
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
               v = int'($urandom_range(0, 200)) - 100;
               word.frame = v;
            end else if (roll < 80 || model_count == 0) begin
               word.frame = $urandom;
            end else if (roll < 90) begin
               case ($urandom_range(0, 3))
                  0:       word.frame = 32'h80000000;
                  1:       word.frame = 32'h7fffffff;
                  2:       word.frame = 32'sd0;
                  default: word.frame = -32'sd1;
               endcase
            end else begin
               word.frame = model_times[$urandom_range(0, model_count - 1)];
            end

            roll = $urandom_range(0, 99);
            if (roll < 60 && model_count > 0) begin
               word.position = 6'($urandom_range(0, model_count - 1));
            end else if (roll < 80) begin
               word.position = 6'($urandom_range(0, 63));
            end else begin
               c = model_count + int'($urandom_range(0, 2)) - 1;
               if (c < 0) c = 0;
               if (c > 63) c = 63;
               word.position = c[5:0];
            end

            roll = $urandom_range(0, 99);
            if (calm || roll < 75) gap = 0;
            else if (roll < 95) gap = $urandom_range(1, 3);
            else gap = $urandom_range(5, 40);

            send_word(word, 1'b0, none_rsp, gap);
            if (op_type'(word.operation) != OP_NONE) sent++;
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_rsp.size() != 0) fail_count += pending_rsp.size();

      $display("Covered %0d request words: %0d inserts (%0d duplicates, %0d on a full table),",
               accepted_words, n_insert, n_dup, n_full);
      $display("%0d deletes, %0d reads, %0d out of range, %0d ignored ops, peak size %0d.",
               n_delete, n_read, n_range, n_none, peak_count);
      if (fail_count == 0)
         $display("sorted_point_table verification clean");
      else
         $display("sorted_point_table verification failed");
      $finish;
   end

endmodule

[filelist.f]
sv/spt_pkg.sv
sv/spt_store.sv
sv/sorted_point_table.sv
sv/spt_checker.sv
tb/tb.sv
